/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on clk with rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg
// shared constants, codes and types of the prefix route table
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PORT_COUNT  = 16;

    localparam int ADDR_W = 32;
    localparam int HB_W   = 6;
    localparam int PORT_W = 4;
    localparam int POS_W  = 4;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [HB_W-1:0]   HB_MAX    = HB_W'(32);
    localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BADPOS = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [HB_W-1:0]   host_bits;
        logic [PORT_W-1:0] egress;
    } prt_entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [ADDR_W-1:0] address;
        logic [HB_W-1:0]   host_bits;
        logic [PORT_W-1:0] egress;
        logic [POS_W-1:0]  position;
    } prt_key_t;

    // all-ones shifted left by host bits, zero from 32 up
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [HB_W-1:0] hb);
        logic [ADDR_W-1:0] m;
        begin
            if (hb >= HB_MAX)
                m = '0;
            else
                m = FULL_MASK << hb[4:0];
            return m;
        end
    endfunction

endpackage

/* src/prt_cell.sv */
// ----------------------------------------------------------------------------
// prt_cell
// one table position: holds a route, matches the key, shifts with neighbors
// ----------------------------------------------------------------------------
module prt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::prt_key_t   key,
    input  logic [CNT_W-1:0]    count,
    input  prt_pkg::prt_entry_t left_entry,
    input  logic                left_le,
    input  logic                left_valid,
    input  logic                left_seen,
    input  prt_pkg::prt_entry_t right_entry,
    output prt_pkg::prt_entry_t entry,
    output logic                le,
    output logic                valid,
    output logic                seen,
    output logic                first
);

    prt_pkg::prt_entry_t entry_reg;
    prt_pkg::prt_entry_t entry_next;
    logic                match;
    logic [31:0]         mask;

    assign entry = entry_reg;
    assign mask  = prt_pkg::prefix_mask(entry_reg.host_bits);
    assign valid = 32'(INDEX) < 32'(count);
    assign le    = valid && (entry_reg.host_bits <= key.host_bits);
    assign match = valid && (((key.address ^ entry_reg.network) & mask) == '0);
    assign first = match && !left_seen;
    assign seen  = left_seen || match;

    always_comb
    begin
        entry_next = entry_reg;
        if (key.ins)
        begin
            // the insertion slot is the first cell that is empty or whose host bits exceed the key
            if (!le && left_le)
            begin
                entry_next.network   = key.address;
                entry_next.host_bits = key.host_bits;
                entry_next.egress    = key.egress;
            end
            else if (!left_le && left_valid)
            begin
                entry_next = left_entry;
            end
        end
        else if (key.rem)
        begin
            if (32'(INDEX) >= 32'(key.position))
                entry_next = right_entry;
        end
    end

    // route storage is payload only, unwritten entries lie past the count and never match
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* src/prefix_route_table.sv */
// ----------------------------------------------------------------------------
// prefix_route_table
// sorted ipv4 route table with longest-prefix lookup, insert and remove
// ----------------------------------------------------------------------------
// timing: an accepted item is held in the item registers until the compare
//   and shift pass through the row of cells, which waits while the previous
//   result is still waiting to be taken, then writes the result registers
// a new item is not taken until the pass for the current one is done
// reset: entry count and handshake state clear, route storage is not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefix_route_table #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH,
    parameter int PORT_COUNT  = prt_pkg::PORT_COUNT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [prt_pkg::OP_W-1:0]   opcode,
    input  logic [prt_pkg::ADDR_W-1:0] address,
    input  logic [prt_pkg::HB_W-1:0]   host_bits,
    input  logic [prt_pkg::PORT_W-1:0] entry_port,
    input  logic [prt_pkg::POS_W-1:0]  entry_position,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [prt_pkg::PORT_W-1:0] egress_port,
    output logic                       hit,
    output logic [IDX_W-1:0]           match_position,
    output logic [prt_pkg::STAT_W-1:0] status,
    output logic [CNT_W-1:0]           entry_count
);

    localparam logic [prt_pkg::PORT_W-1:0] PORT_MAX = prt_pkg::PORT_W'(PORT_COUNT - 1);

    logic                       busy_reg;
    logic                       out_valid_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [prt_pkg::OP_W-1:0]   op_reg;
    logic [prt_pkg::ADDR_W-1:0] addr_reg;
    logic [prt_pkg::HB_W-1:0]   hb_reg;
    logic [prt_pkg::PORT_W-1:0] port_reg;
    logic [prt_pkg::POS_W-1:0]  pos_reg;

    logic [prt_pkg::PORT_W-1:0] egress_reg;
    logic                       hit_reg;
    logic [IDX_W-1:0]           mpos_reg;
    logic [prt_pkg::STAT_W-1:0] status_reg;

    logic                       accept;
    logic                       go;
    logic                       full;
    logic                       bad_pos;
    logic                       do_ins;
    logic                       do_rem;
    logic                       is_lookup;
    logic [prt_pkg::STAT_W-1:0] status_next;
    logic [prt_pkg::PORT_W-1:0] egress_sel;
    logic [IDX_W-1:0]           mpos_sel;
    prt_pkg::prt_key_t          key;

    prt_pkg::prt_entry_t        cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     cell_le;
    logic [TABLE_DEPTH-1:0]     cell_valid;
    logic [TABLE_DEPTH-1:0]     cell_seen;
    logic [TABLE_DEPTH-1:0]     cell_first;

    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;
    assign go        = busy_reg && (!out_valid_reg || out_ready);

    assign full      = count_reg == CNT_W'(TABLE_DEPTH);
    assign bad_pos   = 32'(pos_reg) >= 32'(count_reg);
    assign do_ins    = go && (op_reg == prt_pkg::OP_INSERT) && !full;
    assign do_rem    = go && (op_reg == prt_pkg::OP_REMOVE) && !bad_pos;
    assign is_lookup = op_reg == prt_pkg::OP_LOOKUP;

    always_comb
    begin
        key.ins       = do_ins;
        key.rem       = do_rem;
        key.address   = addr_reg;
        key.host_bits = hb_reg;
        key.egress    = port_reg;
        key.position  = pos_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            prt_pkg::prt_entry_t lft;
            prt_pkg::prt_entry_t rgt;
            logic                lft_le;
            logic                lft_valid;
            logic                lft_seen;

            if (g == 0)
            begin : g_head
                // head cell: everything before it counts as fewer host bits
                assign lft       = cell_entry[g];
                assign lft_le    = 1'b1;
                assign lft_valid = 1'b0;
                assign lft_seen  = 1'b0;
            end
            else
            begin : g_body
                assign lft       = cell_entry[g-1];
                assign lft_le    = cell_le[g-1];
                assign lft_valid = cell_valid[g-1];
                assign lft_seen  = cell_seen[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign rgt = cell_entry[g];
            end
            else
            begin : g_mid
                assign rgt = cell_entry[g+1];
            end

            prt_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .key         (key),
                .count       (count_reg),
                .left_entry  (lft),
                .left_le     (lft_le),
                .left_valid  (lft_valid),
                .left_seen   (lft_seen),
                .right_entry (rgt),
                .entry       (cell_entry[g]),
                .le          (cell_le[g]),
                .valid       (cell_valid[g]),
                .seen        (cell_seen[g]),
                .first       (cell_first[g])
            );
        end
    endgenerate

    // at most one cell flags first, so the select is a plain or
    always_comb
    begin
        egress_sel = '0;
        mpos_sel   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_first[i])
            begin
                egress_sel = egress_sel | cell_entry[i].egress;
                mpos_sel   = mpos_sel | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next = prt_pkg::STATUS_OK;
        count_next  = count_reg;
        case (op_reg)
            prt_pkg::OP_INSERT:
            begin
                if (full)
                    status_next = prt_pkg::STATUS_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            prt_pkg::OP_REMOVE:
            begin
                if (bad_pos)
                    status_next = prt_pkg::STATUS_BADPOS;
                else
                    count_next = count_reg - 1'b1;
            end
            default:
            begin
                status_next = prt_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (go)
                busy_reg <= 1'b0;

            if (go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (go)
                count_reg <= count_next;
        end
    end

    // item capture with saturation of host bits and port, result capture on each pass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            hb_reg   <= (host_bits > prt_pkg::HB_MAX) ? prt_pkg::HB_MAX : host_bits;
            port_reg <= (32'(entry_port) >= 32'(PORT_COUNT)) ? PORT_MAX : entry_port;
            pos_reg  <= entry_position;
        end
        if (go)
        begin
            egress_reg <= is_lookup ? egress_sel : '0;
            hit_reg    <= is_lookup && (|cell_first);
            mpos_reg   <= is_lookup ? mpos_sel : '0;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign egress_port    = egress_reg;
    assign hit            = hit_reg;
    assign match_position = mpos_reg;
    assign status         = status_reg;
    assign entry_count    = count_reg;

    `ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(TABLE_DEPTH))
    `ASSERT_ALWAYS(a_first_unique, $onehot0(cell_first))
    `ASSERT_IMPL(a_hit_status, out_valid_reg && hit_reg, status_reg == prt_pkg::STATUS_OK)
    `ASSERT_NEXT(a_insert_grows, do_ins, count_reg == $past(count_reg) + 1'b1)

endmodule
